// ----- hw/rtl/rgbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared types and constants of the RGB LED frame builder with fade.
// ----------------------------------------------------------------------------
package rgbf_pkg;

    // event codes carried by an input item
    typedef enum logic [2:0] {
        MODE_FADE_DOWN = 3'd0,
        MODE_FADE_UP   = 3'd1,
        MODE_BLANK     = 3'd2,
        MODE_RESTORE   = 3'd3,
        MODE_SEND      = 3'd4
    } t_mode;

    // configuration register indexes
    localparam logic [2:0] REG_LED0    = 3'd0;
    localparam logic [2:0] REG_LED1    = 3'd1;
    localparam logic [2:0] REG_LED2    = 3'd2;
    localparam logic [2:0] REG_LED3    = 3'd3;
    localparam logic [2:0] REG_PERCENT = 3'd4;
    localparam logic [2:0] REG_FUNC    = 3'd5;

    localparam int          LED_COUNT   = 4;
    localparam int          FRAME_BYTES = 28;
    localparam logic [4:0]  LAST_POS    = 5'(FRAME_BYTES - 1);
    localparam logic [5:0]  FRAME_CMD   = 6'h25;
    localparam logic [6:0]  LEVEL_MAX   = 7'h7F;
    localparam logic [4:0]  FUNC_RESET  = 5'd22;

    // 127 * p / 100 as p * (127 * 5243) >> 19, exact for any 7-bit p
    localparam logic [19:0] PCT_RECIP   = 20'd665861;
    localparam int          RECIP_SHIFT = 19;

    // result of one level event
    typedef struct packed {
        logic [6:0] level;
        logic       done;
        logic       emit;   // status item goes out
        logic       send;   // frame burst
    } t_lvl_res;

endpackage

// ----- hw/rtl/rgb_led_frame_builder_with_fade_core.sv -----
// ----------------------------------------------------------------------------
// rgb_led_frame_builder_with_fade_core
// Global brightness fade and 28-byte driver frame builder for four RGB LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   slave channel carries events: tuser holds the event code (fade down,
//   fade up, blank, restore, send), tdata the fade step.
//   master channel carries results: tdata holds frame byte, level and
//   fade-finished flag, tlast marks the final result of an event.
//   config channel writes LED colors, target percent and function bits;
//   it is always ready and is used while no event is in flight.
// Registers: an accepted event passes through the input register, then the
//   output register, before its result is valid.
// Throughput: fade, blank and restore give one result each; a send gives the
//   whole frame, one frame byte per cycle through the single output register
//   while the receiver does not stall. Unknown codes are dropped with no result.
// Reset: level, colors and percent go to zero, function bits to 22, both
//   registers empty.
// Stall: while the receiver holds tready low the output item holds, the
//   frame counter stops, and the input side fills its one register and then
//   drops tready.
// ----------------------------------------------------------------------------
module rgb_led_frame_builder_with_fade_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [6:0] fade_step, [7] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] mode
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] frame_byte, [14:8] level, [15] fade_done
    output logic        o_m_tlast,   // last_byte
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import rgbf_pkg::*;

    // configuration registers
    logic [23:0] r_led [LED_COUNT];
    logic [6:0]  r_target;
    logic [4:0]  r_func;

    // event register and state
    logic        r_in_valid;
    logic [2:0]  r_in_mode;
    logic [6:0]  r_in_step;
    logic [6:0]  r_level;
    logic [4:0]  r_pos;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [6:0]  r_out_level;
    logic        r_out_done;
    logic        r_out_last;

    logic [26:0] w_tprod;
    logic [7:0]  w_tquot;
    logic [6:0]  n_target;
    t_lvl_res    w_res;
    logic        w_out_free;
    logic        w_fire;
    logic        w_consume;
    logic        w_pos_last;
    logic [4:0]  w_off;
    logic [3:0]  w_slot;
    logic [1:0]  w_led;
    logic [1:0]  w_ch;
    logic [23:0] w_color;
    logic [7:0]  w_byte;

    assign o_cfg_ready = 1'b1;

    // target level from percent, saturating
    assign w_tprod  = 27'(i_cfg_data[6:0]) * 27'(PCT_RECIP);
    assign w_tquot  = w_tprod[RECIP_SHIFT +: 8];
    assign n_target = (w_tquot > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : w_tquot[6:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_led[i] <= '0;
            end
            r_target <= '0;
            r_func   <= FUNC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LED0:    r_led[0] <= i_cfg_data;
                REG_LED1:    r_led[1] <= i_cfg_data;
                REG_LED2:    r_led[2] <= i_cfg_data;
                REG_LED3:    r_led[3] <= i_cfg_data;
                REG_PERCENT: r_target <= n_target;
                REG_FUNC:    r_func   <= i_cfg_data[4:0];
                default:     r_func   <= r_func;
            endcase
        end
    end

    rgbf_level_unit u_level (
        .i_mode   (r_in_mode),
        .i_step   (r_in_step),
        .i_level  (r_level),
        .i_target (r_target),
        .o_res    (w_res)
    );

    // event scheduling
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_pos_last = (r_pos == LAST_POS);
    assign w_fire     = r_in_valid && (w_out_free || !(w_res.emit || w_res.send));
    assign w_consume  = w_fire && (!w_res.send || w_pos_last);
    assign o_s_tready = !r_in_valid || w_consume;

    // color slot of the current frame byte
    assign w_off  = r_pos - 5'd4;
    assign w_slot = w_off[4:1];

    always_comb begin
        case (w_slot)
            4'd0:    begin w_led = 2'd3; w_ch = 2'd0; end
            4'd1:    begin w_led = 2'd3; w_ch = 2'd1; end
            4'd2:    begin w_led = 2'd3; w_ch = 2'd2; end
            4'd3:    begin w_led = 2'd2; w_ch = 2'd0; end
            4'd4:    begin w_led = 2'd2; w_ch = 2'd1; end
            4'd5:    begin w_led = 2'd2; w_ch = 2'd2; end
            4'd6:    begin w_led = 2'd1; w_ch = 2'd0; end
            4'd7:    begin w_led = 2'd1; w_ch = 2'd1; end
            4'd8:    begin w_led = 2'd1; w_ch = 2'd2; end
            4'd9:    begin w_led = 2'd0; w_ch = 2'd0; end
            4'd10:   begin w_led = 2'd0; w_ch = 2'd1; end
            4'd11:   begin w_led = 2'd0; w_ch = 2'd2; end
            default: begin w_led = 2'd0; w_ch = 2'd0; end
        endcase
    end

    assign w_color = r_led[w_led];

    // frame byte select: header, then color bytes each sent twice
    always_comb begin
        case (r_pos)
            5'd0:    w_byte = {FRAME_CMD, r_func[4:3]};
            5'd1:    w_byte = {r_func[2:0], r_level[6:2]};
            5'd2:    w_byte = {r_level[1:0], r_level[6:1]};
            5'd3:    w_byte = {r_level[0], r_level};
            default: begin
                case (w_ch)
                    2'd0:    w_byte = w_color[7:0];
                    2'd1:    w_byte = w_color[15:8];
                    default: w_byte = w_color[23:16];
                endcase
            end
        endcase
    end

    // input register, level and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_level    <= '0;
            r_pos      <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_consume && !w_res.send) begin
                r_level <= w_res.level;
            end
            if (w_fire && w_res.send) begin
                r_pos <= w_pos_last ? 5'd0 : (r_pos + 5'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_mode <= i_s_tuser;
            r_in_step <= i_s_tdata[6:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && (w_res.emit || w_res.send)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.send) begin
            r_out_byte  <= w_byte;
            r_out_level <= r_level;
            r_out_done  <= 1'b0;
            r_out_last  <= w_pos_last;
        end else if (w_fire && w_res.emit) begin
            r_out_byte  <= 8'd0;
            r_out_level <= w_res.level;
            r_out_done  <= w_res.done;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_done, r_out_level, r_out_byte};
    assign o_m_tlast  = r_out_last;

endmodule

// ----- hw/rtl/rgbf_level_unit.sv -----
// ----------------------------------------------------------------------------
// rgbf_level_unit
// Next brightness level and fade-finished flag for one event.
// ----------------------------------------------------------------------------
module rgbf_level_unit (
    input  logic [2:0]        i_mode,
    input  logic [6:0]        i_step,
    input  logic [6:0]        i_level,
    input  logic [6:0]        i_target,
    output rgbf_pkg::t_lvl_res o_res
);
    import rgbf_pkg::*;

    logic [7:0] w_sum;

    assign w_sum = {1'b0, i_level} + {1'b0, i_step};

    // level update per event
    always_comb begin
        o_res.level = i_level;
        o_res.done  = 1'b0;
        o_res.emit  = 1'b0;
        o_res.send  = 1'b0;
        case (t_mode'(i_mode))
            MODE_FADE_DOWN: begin
                o_res.level = (i_level > i_step) ? (i_level - i_step) : 7'd0;
                o_res.done  = (i_level <= i_step);
                o_res.emit  = 1'b1;
            end
            MODE_FADE_UP: begin
                o_res.level = (w_sum < {1'b0, i_target}) ? w_sum[6:0] : i_target;
                o_res.done  = (w_sum >= {1'b0, i_target});
                o_res.emit  = 1'b1;
            end
            MODE_BLANK: begin
                o_res.level = 7'd0;
                o_res.emit  = 1'b1;
            end
            MODE_RESTORE: begin
                o_res.level = i_target;
                o_res.emit  = 1'b1;
            end
            MODE_SEND: begin
                o_res.send  = 1'b1;
            end
            default: begin
                o_res.level = i_level;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rgbf_checker.sv -----
// ----------------------------------------------------------------------------
// rgbf_checker
// Port-level checks of the frame builder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rgbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic [2:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [23:0] i_cfg_data
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result item changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // fade-finished only on a single status item with zero frame byte
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[15] |-> o_m_tlast && (o_m_tdata[7:0] == 8'd0))
        else $error("fade flag on a frame byte");

    // frame bytes before the last never carry the fade flag
    a_frame_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_m_tdata[15])
        else $error("fade flag inside a frame");

endmodule

bind rgb_led_frame_builder_with_fade_core rgbf_checker u_rgbf_checker (.*);
